// ----- src/ps2mct_pkg.sv -----
package ps2mct_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [COORD_W-1:0] POS_X_RESET   = 12'd370;
    localparam logic [COORD_W-1:0] POS_Y_RESET   = 12'd310;
    localparam logic [COORD_W-1:0] X_LIMIT_RESET = 12'd1024;
    localparam logic [COORD_W-1:0] Y_LIMIT_RESET = 12'd768;

    localparam int unsigned HDR_LEFT  = 0;
    localparam int unsigned HDR_RIGHT = 1;
    localparam int unsigned HDR_SYNC  = 3;
    localparam int unsigned HDR_XSIGN = 4;
    localparam int unsigned HDR_YSIGN = 5;
    localparam int unsigned HDR_XOVF  = 6;
    localparam int unsigned HDR_YOVF  = 7;

    localparam logic REG_X_LIMIT = 1'b0;
    localparam logic REG_Y_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        MOVE_OK        = 2'd0,
        MOVE_OVERFLOW  = 2'd1,
        MOVE_OFFSCREEN = 2'd2
    } move_status_t;

    typedef enum logic [1:0] {
        PKT_HEADER = 2'd0,
        PKT_XDELTA = 2'd1,
        PKT_YDELTA = 2'd2
    } pkt_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        move_status_t       status;
    } move_result_t;

endpackage

// ----- src/ps2mct_move.sv -----
module ps2mct_move (
    input  logic [ps2mct_pkg::BYTE_W-1:0]  header,
    input  logic [ps2mct_pkg::BYTE_W-1:0]  x_byte,
    input  logic [ps2mct_pkg::BYTE_W-1:0]  y_byte,
    input  logic [ps2mct_pkg::COORD_W-1:0] pos_x,
    input  logic [ps2mct_pkg::COORD_W-1:0] pos_y,
    input  logic [ps2mct_pkg::COORD_W-1:0] x_limit,
    input  logic [ps2mct_pkg::COORD_W-1:0] y_limit,
    output ps2mct_pkg::move_result_t       result
);

    localparam int unsigned SUM_W = ps2mct_pkg::COORD_W + 2;

    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic signed [SUM_W-1:0] nx;
    logic signed [SUM_W-1:0] ny;
    logic                    x_out;
    logic                    y_out;

    always_comb begin
        dx = $signed({{(SUM_W-ps2mct_pkg::BYTE_W){header[ps2mct_pkg::HDR_XSIGN]}}, x_byte});
        dy = $signed({{(SUM_W-ps2mct_pkg::BYTE_W){header[ps2mct_pkg::HDR_YSIGN]}}, y_byte});
        nx = $signed({2'b00, pos_x}) + dx;
        ny = $signed({2'b00, pos_y}) - dy;
        x_out = nx[SUM_W-1] || (nx[SUM_W-2:0] > {1'b0, x_limit});
        y_out = ny[SUM_W-1] || (ny[SUM_W-2:0] > {1'b0, y_limit});

        result.pos_x  = pos_x;
        result.pos_y  = pos_y;
        result.status = ps2mct_pkg::MOVE_OK;
        if (header[ps2mct_pkg::HDR_XOVF] || header[ps2mct_pkg::HDR_YOVF]) begin
            result.status = ps2mct_pkg::MOVE_OVERFLOW;
        end else if (x_out || y_out) begin
            result.status = ps2mct_pkg::MOVE_OFFSCREEN;
        end else begin
            result.pos_x = nx[ps2mct_pkg::COORD_W-1:0];
            result.pos_y = ny[ps2mct_pkg::COORD_W-1:0];
        end
    end

endmodule

// ----- src/ps2_mouse_cursor_tracker_core.sv -----
// The word for a packet's third byte is held in the result register, from which it drives m_axis.
// Throughput: one byte per cycle; s_axis_tready falls only while a result waits on m_axis.
// A packet gives one word after its third byte; stray bytes give none.
// Reset (aresetn low, synchronous): hunt for a header, cursor at (370, 310),
// limits 1024 x 768, result register empty.
module ps2_mouse_cursor_tracker_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [0] left_button, [1] right_button, [13:2] cursor_x,
                                        // [25:14] cursor_y, [27:26] move_status, [31:28] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CW = ps2mct_pkg::COORD_W;

    ps2mct_pkg::pkt_state_t   state_reg, state_next;
    logic [7:0]               header_reg, header_next;
    logic [7:0]               xbyte_reg, xbyte_next;
    logic [CW-1:0]            pos_x_reg, pos_x_next;
    logic [CW-1:0]            pos_y_reg, pos_y_next;
    logic [CW-1:0]            x_limit_reg, x_limit_next;
    logic [CW-1:0]            y_limit_reg, y_limit_next;
    logic                     out_valid_reg, out_valid_next;
    logic [31:0]              out_data_reg, out_data_next;

    logic                     s_accept;
    logic                     cfg_write;
    logic                     take_header;
    logic                     take_xbyte;
    logic                     emit;
    ps2mct_pkg::move_result_t move;

    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite && pready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    ps2mct_move u_move (
        .header  (header_reg),
        .x_byte  (xbyte_reg),
        .y_byte  (s_axis_tdata),
        .pos_x   (pos_x_reg),
        .pos_y   (pos_y_reg),
        .x_limit (x_limit_reg),
        .y_limit (y_limit_reg),
        .result  (move)
    );

    always_comb begin
        state_next = state_reg;
        if (s_accept) begin
            unique case (state_reg)
                ps2mct_pkg::PKT_HEADER: begin
                    if (s_axis_tdata[ps2mct_pkg::HDR_SYNC]) begin
                        state_next = ps2mct_pkg::PKT_XDELTA;
                    end
                end
                ps2mct_pkg::PKT_XDELTA: state_next = ps2mct_pkg::PKT_YDELTA;
                ps2mct_pkg::PKT_YDELTA: state_next = ps2mct_pkg::PKT_HEADER;
                default:                state_next = ps2mct_pkg::PKT_HEADER;
            endcase
        end
    end

    always_comb begin
        take_header = 1'b0;
        take_xbyte  = 1'b0;
        emit        = 1'b0;
        unique case (state_reg)
            ps2mct_pkg::PKT_HEADER: take_header = s_accept && s_axis_tdata[ps2mct_pkg::HDR_SYNC];
            ps2mct_pkg::PKT_XDELTA: take_xbyte  = s_accept;
            ps2mct_pkg::PKT_YDELTA: emit        = s_accept;
            default: begin
            end
        endcase
    end

    always_comb begin
        header_next    = take_header ? s_axis_tdata : header_reg;
        xbyte_next     = take_xbyte ? s_axis_tdata : xbyte_reg;
        pos_x_next     = emit ? move.pos_x : pos_x_reg;
        pos_y_next     = emit ? move.pos_y : pos_y_reg;
        x_limit_next   = x_limit_reg;
        y_limit_next   = y_limit_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                ps2mct_pkg::REG_X_LIMIT: x_limit_next = pwdata[CW-1:0];
                ps2mct_pkg::REG_Y_LIMIT: y_limit_next = pwdata[CW-1:0];
                default: begin
                end
            endcase
        end
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {4'b0000, move.status, move.pos_y, move.pos_x,
                              header_reg[ps2mct_pkg::HDR_RIGHT],
                              header_reg[ps2mct_pkg::HDR_LEFT]};
        end
    end

    always_comb begin
        unique case (paddr[2])
            ps2mct_pkg::REG_X_LIMIT: prdata = {{(32-CW){1'b0}}, x_limit_reg};
            ps2mct_pkg::REG_Y_LIMIT: prdata = {{(32-CW){1'b0}}, y_limit_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ps2mct_pkg::PKT_HEADER;
            pos_x_reg     <= ps2mct_pkg::POS_X_RESET;
            pos_y_reg     <= ps2mct_pkg::POS_Y_RESET;
            x_limit_reg   <= ps2mct_pkg::X_LIMIT_RESET;
            y_limit_reg   <= ps2mct_pkg::Y_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            x_limit_reg   <= x_limit_next;
            y_limit_reg   <= y_limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        header_reg   <= header_next;
        xbyte_reg    <= xbyte_next;
        out_data_reg <= out_data_next;
    end

    a_third_byte_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && state_reg == ps2mct_pkg::PKT_YDELTA |=> out_valid_reg)
        else $error("third byte gave no result");

    a_no_sync_drops: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && state_reg == ps2mct_pkg::PKT_HEADER && !s_axis_tdata[ps2mct_pkg::HDR_SYNC]
        |=> state_reg == ps2mct_pkg::PKT_HEADER)
        else $error("byte without sync bit left header hunt");

    a_pos_moves_only_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !(emit && move.status == ps2mct_pkg::MOVE_OK)
        |=> $stable(pos_x_reg) && $stable(pos_y_reg))
        else $error("cursor moved without a valid move");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

// ----- tb/ps2_mouse_cursor_tracker_core_tb.sv -----
module ps2_mouse_cursor_tracker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_WORDS  = 155;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                           left;
        logic                           right;
        logic [ps2mct_pkg::COORD_W-1:0] x;
        logic [ps2mct_pkg::COORD_W-1:0] y;
        ps2mct_pkg::move_status_t       status;
    } cursor_report_t;

    typedef struct packed {
        logic [ps2mct_pkg::BYTE_W-1:0] data;
        logic                          chk;
        cursor_report_t                rep;
    } mouse_row_t;

    localparam cursor_report_t UNCHECKED = '{1'b0, 1'b0, 12'd0, 12'd0, ps2mct_pkg::MOVE_OK};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    cursor_report_t pending_reports[$];
    int             mismatches = 0;
    int             idle_cycles = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    ps2mct_pkg::pkt_state_t         trk_stage;
    logic [ps2mct_pkg::BYTE_W-1:0]  trk_header;
    logic [ps2mct_pkg::BYTE_W-1:0]  trk_xdelta;
    logic [ps2mct_pkg::COORD_W-1:0] trk_x;
    logic [ps2mct_pkg::COORD_W-1:0] trk_y;
    logic [ps2mct_pkg::COORD_W-1:0] trk_xlim;
    logic [ps2mct_pkg::COORD_W-1:0] trk_ylim;

    mouse_row_t directed_rows[20];

    ps2_mouse_cursor_tracker_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit track_mouse_byte(input logic [ps2mct_pkg::BYTE_W-1:0] b,
                                            output cursor_report_t rep);
        int dx;
        int dy;
        int nx;
        int ny;
        rep = UNCHECKED;
        case (trk_stage)
            ps2mct_pkg::PKT_XDELTA: begin
                trk_xdelta = b;
                trk_stage = ps2mct_pkg::PKT_YDELTA;
                return 1'b0;
            end
            ps2mct_pkg::PKT_YDELTA: begin
                trk_stage = ps2mct_pkg::PKT_HEADER;
                dx = int'(trk_xdelta) - (trk_header[ps2mct_pkg::HDR_XSIGN] ? 256 : 0);
                dy = int'(b) - (trk_header[ps2mct_pkg::HDR_YSIGN] ? 256 : 0);
                nx = int'(trk_x) + dx;
                ny = int'(trk_y) - dy;
                if (trk_header[ps2mct_pkg::HDR_XOVF] || trk_header[ps2mct_pkg::HDR_YOVF]) begin
                    rep.status = ps2mct_pkg::MOVE_OVERFLOW;
                end else if (nx < 0 || nx > int'(trk_xlim) ||
                             ny < 0 || ny > int'(trk_ylim)) begin
                    rep.status = ps2mct_pkg::MOVE_OFFSCREEN;
                end else begin
                    trk_x = nx[ps2mct_pkg::COORD_W-1:0];
                    trk_y = ny[ps2mct_pkg::COORD_W-1:0];
                    rep.status = ps2mct_pkg::MOVE_OK;
                end
                rep.left  = trk_header[ps2mct_pkg::HDR_LEFT];
                rep.right = trk_header[ps2mct_pkg::HDR_RIGHT];
                rep.x     = trk_x;
                rep.y     = trk_y;
                return 1'b1;
            end
            default: begin
                trk_stage = ps2mct_pkg::PKT_HEADER;
                if (b[ps2mct_pkg::HDR_SYNC]) begin
                    trk_header = b;
                    trk_stage = ps2mct_pkg::PKT_XDELTA;
                end
                return 1'b0;
            end
        endcase
    endfunction

    task automatic send_byte(input logic [ps2mct_pkg::BYTE_W-1:0] b, input bit chk = 1'b0,
                             input cursor_report_t typed = UNCHECKED);
        cursor_report_t rep;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        if (track_mouse_byte(b, rep))
            pending_reports.push_back(chk ? typed : rep);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_limit(input logic idx,
                               input logic [ps2mct_pkg::COORD_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == ps2mct_pkg::REG_X_LIMIT)
            trk_xlim = value;
        else
            trk_ylim = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (recv_stall_pct == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        cursor_report_t want;
        cursor_report_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.left   = m_axis_tdata[0];
            got.right  = m_axis_tdata[1];
            got.x      = m_axis_tdata[13:2];
            got.y      = m_axis_tdata[25:14];
            got.status = ps2mct_pkg::move_status_t'(m_axis_tdata[27:26]);
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: L%0d R%0d X%0d Y%0d S%0d",
                             got.left, got.right, got.x, got.y, got.status);
            end else begin
                want = pending_reports.pop_front();
                if (got.left !== want.left || got.right !== want.right ||
                    got.x !== want.x || got.y !== want.y || got.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("expected L%0d R%0d X%0d Y%0d S%0d got L%0d R%0d X%0d Y%0d S%0d",
                                 want.left, want.right, want.x, want.y, want.status,
                                 got.left, got.right, got.x, got.y, got.status);
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int                             sent;
        bit                             drained_mid;
        logic [ps2mct_pkg::BYTE_W-1:0]  hdr;
        logic [ps2mct_pkg::COORD_W-1:0] xl;
        logic [ps2mct_pkg::COORD_W-1:0] yl;

        trk_stage  = ps2mct_pkg::PKT_HEADER;
        trk_header = '0;
        trk_xdelta = '0;
        trk_x      = ps2mct_pkg::POS_X_RESET;
        trk_y      = ps2mct_pkg::POS_Y_RESET;
        trk_xlim   = ps2mct_pkg::X_LIMIT_RESET;
        trk_ylim   = ps2mct_pkg::Y_LIMIT_RESET;

        directed_rows = '{
            '{8'h00, 1'b0, UNCHECKED},
            '{8'hF7, 1'b0, UNCHECKED},
            '{8'h08, 1'b0, UNCHECKED},
            '{8'h00, 1'b0, UNCHECKED},
            '{8'h00, 1'b1, '{1'b0, 1'b0, 12'd370, 12'd310, ps2mct_pkg::MOVE_OK}},
            '{8'hFF, 1'b0, UNCHECKED},
            '{8'hFF, 1'b0, UNCHECKED},
            '{8'hFF, 1'b1, '{1'b1, 1'b1, 12'd370, 12'd310, ps2mct_pkg::MOVE_OVERFLOW}},
            '{8'h49, 1'b0, UNCHECKED},
            '{8'h80, 1'b0, UNCHECKED},
            '{8'h80, 1'b1, '{1'b1, 1'b0, 12'd370, 12'd310, ps2mct_pkg::MOVE_OVERFLOW}},
            '{8'h0A, 1'b0, UNCHECKED},
            '{8'hFF, 1'b0, UNCHECKED},
            '{8'h00, 1'b1, '{1'b0, 1'b1, 12'd625, 12'd310, ps2mct_pkg::MOVE_OK}},
            '{8'h38, 1'b0, UNCHECKED},
            '{8'h00, 1'b0, UNCHECKED},
            '{8'h00, 1'b0, UNCHECKED},
            '{8'h28, 1'b0, UNCHECKED},
            '{8'h08, 1'b0, UNCHECKED},
            '{8'h00, 1'b0, UNCHECKED}
        };

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].chk, directed_rows[i].rep);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin xl = 12'd4095; yl = 12'd4095; end
                1: begin xl = 12'd300;  yl = 12'd200;  end
                2: begin xl = 12'd0;    yl = 12'd0;    end
                3: begin xl = 12'($urandom_range(4095)); yl = 12'($urandom_range(4095)); end
                4: begin xl = 12'd4095; yl = 12'd0;    end
                default: begin xl = 12'($urandom_range(600)); yl = 12'($urandom_range(600)); end
            endcase
            write_limit(ps2mct_pkg::REG_X_LIMIT, xl);
            write_limit(ps2mct_pkg::REG_Y_LIMIT, yl);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase

            sent = 0;
            drained_mid = 1'b0;
            while (sent < PHASE_WORDS) begin
                if (!drained_mid && sent >= PHASE_WORDS / 2) begin
                    wait_drained();
                    drained_mid = 1'b1;
                end
                if ($urandom_range(99) < 85) begin
                    hdr = 8'($urandom_range(255));
                    hdr[ps2mct_pkg::HDR_SYNC] = 1'b1;
                    if ($urandom_range(7) != 0) begin
                        hdr[ps2mct_pkg::HDR_XOVF] = 1'b0;
                        hdr[ps2mct_pkg::HDR_YOVF] = 1'b0;
                    end
                    send_byte(hdr);
                    send_byte(8'($urandom_range(255)));
                    send_byte(8'($urandom_range(255)));
                    sent += 3;
                end else begin
                    send_byte(8'($urandom_range(255)));
                    sent++;
                end
            end
            wait_drained();
        end

        repeat (4) @(posedge aclk);
        if (pending_reports.size() != 0)
            $display("%0d expected words never arrived", pending_reports.size());
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
